// ----- rtl/slpm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpm_pkg: shared types and constants for the sharpen / luma / palette block
// Row store geometry, command and register codes, the sharpen kernel and the
// state types of the sequencer and of the brightness unit.
// ----------------------------------------------------------------------------
package slpm_pkg;

	// row store and palette geometry
	localparam int MAX_WIDTH     = 2048;
	localparam int PALETTE_DEPTH = 256;
	localparam int ADDR_W        = $clog2(MAX_WIDTH);
	localparam int WCNT_W        = $clog2(MAX_WIDTH + 1);
	localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
	localparam int PIX_W         = 24;
	localparam int CFG_W         = 12;
	localparam int ROW_W         = 12;
	localparam int MAX_HEIGHT    = 4095;

	// brightness arithmetic, Q10 weights
	localparam int SUM_W   = 27;
	localparam int ROOT_SH = 5;
	localparam logic [9:0] WGT_R = 10'd306;
	localparam logic [9:0] WGT_G = 10'd601;
	localparam logic [9:0] WGT_B = 10'd147;
	localparam logic [SUM_W-1:0] BIT_START = SUM_W'(1) << (SUM_W - 1);

	// palette blue offset
	localparam logic [7:0] BLUE_OFS = 8'd25;

	// command codes carried in tuser
	localparam logic [1:0] CMD_PAL   = 2'd0;
	localparam logic [1:0] CMD_PIXEL = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;

	// configuration register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// configuration reset values
	localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;

	typedef logic [PIX_W-1:0] pix_t;

	// main sequencer
	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE,
		ST_P_RD0, ST_P_RD1, ST_P_RD2, ST_P_WR0, ST_P_WR1,
		ST_F_RD0, ST_F_RD1, ST_F_RD2, ST_F_RD3,
		ST_LUMA_GO, ST_LUMA_WAIT, ST_OUT
	} top_state_t;

	// brightness unit phases
	typedef enum logic [1:0] {LP_IDLE, LP_SQ, LP_SUM, LP_ROOT} luma_phase_t;

	// brightness unit status toward the sequencer
	typedef struct packed {
		logic       done;
		logic [7:0] lum;
	} luma_res_t;

	// 5*centre minus four neighbours per channel, clamped to 0..255
	function automatic pix_t sharpen(input pix_t c, input pix_t u, input pix_t d,
	                                 input pix_t l, input pix_t r);
		pix_t               res;
		logic signed [12:0] v;
		res = '0;
		for (int k = 0; k < 3; k++) begin
			v = 13'sd5 * $signed({5'd0, c[8*k +: 8]})
			    - $signed({5'd0, u[8*k +: 8]}) - $signed({5'd0, d[8*k +: 8]})
			    - $signed({5'd0, l[8*k +: 8]}) - $signed({5'd0, r[8*k +: 8]});
			if (v < 13'sd0)
				res[8*k +: 8] = 8'd0;
			else if (v > 13'sd255)
				res[8*k +: 8] = 8'd255;
			else
				res[8*k +: 8] = v[7:0];
		end
		return res;
	endfunction

endpackage

// ----- rtl/slpm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpm_ram: simple dual-port synchronous memory
// One write port and one read port; read data registered, held when idle.
// ----------------------------------------------------------------------------
module slpm_ram #(
	parameter int DEPTH  = 2048,
	parameter int DATA_W = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ----- rtl/slpm_luma.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpm_luma: brightness of one sharpened pixel
// Squares, Q10 weighted sum, then a digit-by-digit square root, one result
// bit per cycle; result is floor(root/32) clamped to 255.
// ----------------------------------------------------------------------------
module slpm_luma (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  slpm_pkg::pix_t     pix,
	output slpm_pkg::luma_res_t res
);

	slpm_pkg::luma_phase_t phase_q, phase_nx;
	slpm_pkg::pix_t        pix_s1;
	logic [15:0]           sqb_s2, sqg_s2, sqr_s2;
	logic [slpm_pkg::SUM_W-1:0] rem_q, root_q, bit_q, trial;
	logic [slpm_pkg::SUM_W-1:0] lum_wide;

	// next phase
	always_comb begin
		phase_nx = phase_q;
		unique case (phase_q)
			slpm_pkg::LP_IDLE: if (start) phase_nx = slpm_pkg::LP_SQ;
			slpm_pkg::LP_SQ:   phase_nx = slpm_pkg::LP_SUM;
			slpm_pkg::LP_SUM:  phase_nx = slpm_pkg::LP_ROOT;
			slpm_pkg::LP_ROOT: if (bit_q == '0) phase_nx = slpm_pkg::LP_IDLE;
			default:           phase_nx = slpm_pkg::LP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= slpm_pkg::LP_IDLE;
		else
			phase_q <= phase_nx;
	end

	// datapath: capture, squares, weighted sum, root iterations
	assign trial = root_q + bit_q;

	always_ff @(posedge clk) begin
		if (phase_q == slpm_pkg::LP_IDLE && start)
			pix_s1 <= pix;
		if (phase_q == slpm_pkg::LP_SQ) begin
			sqb_s2 <= pix_s1[7:0] * pix_s1[7:0];
			sqg_s2 <= pix_s1[15:8] * pix_s1[15:8];
			sqr_s2 <= pix_s1[23:16] * pix_s1[23:16];
		end
		if (phase_q == slpm_pkg::LP_SUM) begin
			rem_q  <= slpm_pkg::SUM_W'(sqr_s2 * slpm_pkg::WGT_R)
			          + slpm_pkg::SUM_W'(sqg_s2 * slpm_pkg::WGT_G)
			          + slpm_pkg::SUM_W'(sqb_s2 * slpm_pkg::WGT_B);
			root_q <= '0;
			bit_q  <= slpm_pkg::BIT_START;
		end
		if (phase_q == slpm_pkg::LP_ROOT && bit_q != '0) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// outputs
	assign lum_wide = root_q >> slpm_pkg::ROOT_SH;

	always_comb begin
		res.done = (phase_q == slpm_pkg::LP_ROOT) && (bit_q == '0);
		res.lum  = (lum_wide > slpm_pkg::SUM_W'(255)) ? 8'd255 : lum_wide[7:0];
	end

	// the root bit walks as a single one
	a_bit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == slpm_pkg::LP_ROOT |-> $onehot0(bit_q))
		else $error("root bit not one-hot");
	// a new start is only taken while the unit is free
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> phase_q == slpm_pkg::LP_IDLE)
		else $error("start while busy");
	// done is raised only after the root phase has run
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> $past(phase_q) == slpm_pkg::LP_ROOT)
		else $error("done without iterations");

endmodule

// ----- rtl/sharpen_luma_palette_map_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharpen_luma_palette_map_top: 3x3 sharpen, brightness and palette lookup
// Raster BGR pixels are sharpened against two row stores, reduced to
// brightness and mapped through a 256-entry palette; output lags one row.
//
//  channel  dir  handshake                 payload
//  s_axis   in   tvalid/tready             tdata, tuser (command)
//  m_axis   out  tvalid/tready             tdata, tuser, tlast
//  cfg      in   cfg_we                    cfg_addr, cfg_wdata
//
// A pixel transaction passes through the row store access states P_RD0 to
// P_WR1; each result then goes through start, squares, sum, 14 square root
// steps, done with palette read and output load; a flush passes through
// F_RD0 to F_RD3 before one result. Palette writes are taken in idle.
// After reset a clearing pass over all 2048 entries zeroes both row stores;
// input is held off meanwhile. A full output register stalls the sequencer and so the input.
// ----------------------------------------------------------------------------
module sharpen_luma_palette_map_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // pixel_blue, pixel_green, pixel_red, palette_index
	input  logic [1:0]  s_axis_tuser,  // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // out_blue, out_green, out_red
	output logic        m_axis_tuser,  // frame_done
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [11:0] cfg_wdata
);

	localparam int AW = slpm_pkg::ADDR_W;

	slpm_pkg::top_state_t state_q, state_nx;

	logic [slpm_pkg::CFG_W-1:0]  width_q, height_q;
	logic [slpm_pkg::WCNT_W-1:0] w_eff;
	logic [slpm_pkg::ROW_W-1:0]  h_eff;
	logic [AW-1:0]               col_q, clr_q;
	logic [slpm_pkg::ROW_W-1:0]  row_q;
	logic                        lastcol;
	logic                        accept;

	slpm_pkg::pix_t pix_q, win0_q, win1_q, win2_q;
	slpm_pkg::pix_t rgt_q, upa_q, upb_q, ctr_q, old_q, lft_q;
	slpm_pkg::pix_t sh0_q, sh1_q, up0, up1, left0;
	logic           em0_q, em1_q, sel_q, fdone_q;
	logic           out_free, out_load;

	// memory ports
	logic           row_we, new_re, old_re;
	logic [AW-1:0]  row_waddr, new_raddr, old_raddr;
	slpm_pkg::pix_t old_wdata, new_wdata, new_rdata, old_rdata;
	logic           pal_we, pal_re;
	slpm_pkg::pix_t pal_wdata, pal_rdata;

	slpm_pkg::luma_res_t luma;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= slpm_pkg::WIDTH_RST;
			height_q <= slpm_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				slpm_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_wdata;
				slpm_pkg::REG_FRAME_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// clamped frame geometry
	always_comb begin
		if (width_q < slpm_pkg::CFG_W'(2))
			w_eff = slpm_pkg::WCNT_W'(2);
		else if (int'(width_q) > slpm_pkg::MAX_WIDTH)
			w_eff = slpm_pkg::WCNT_W'(slpm_pkg::MAX_WIDTH);
		else
			w_eff = slpm_pkg::WCNT_W'(width_q);
		h_eff   = (height_q < slpm_pkg::CFG_W'(2)) ? slpm_pkg::ROW_W'(2) : height_q;
		lastcol = int'(col_q) >= int'(w_eff) - 1;
	end

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign out_load = (state_q == slpm_pkg::ST_OUT) && out_free;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			slpm_pkg::ST_CLEAR:
				if (clr_q == AW'(slpm_pkg::MAX_WIDTH - 1)) state_nx = slpm_pkg::ST_IDLE;
			slpm_pkg::ST_IDLE:
				if (accept) begin
					case (s_axis_tuser)
						slpm_pkg::CMD_PIXEL:
							if (row_q < h_eff) state_nx = slpm_pkg::ST_P_RD0;
						slpm_pkg::CMD_FLUSH:
							if (row_q >= h_eff) state_nx = slpm_pkg::ST_F_RD0;
						default: ;
					endcase
				end
			slpm_pkg::ST_P_RD0: state_nx = slpm_pkg::ST_P_RD1;
			slpm_pkg::ST_P_RD1: state_nx = slpm_pkg::ST_P_RD2;
			slpm_pkg::ST_P_RD2: state_nx = slpm_pkg::ST_P_WR0;
			slpm_pkg::ST_P_WR0: state_nx = slpm_pkg::ST_P_WR1;
			slpm_pkg::ST_P_WR1:
				state_nx = (em0_q || em1_q) ? slpm_pkg::ST_LUMA_GO : slpm_pkg::ST_IDLE;
			slpm_pkg::ST_F_RD0: state_nx = slpm_pkg::ST_F_RD1;
			slpm_pkg::ST_F_RD1: state_nx = slpm_pkg::ST_F_RD2;
			slpm_pkg::ST_F_RD2: state_nx = slpm_pkg::ST_F_RD3;
			slpm_pkg::ST_F_RD3: state_nx = slpm_pkg::ST_LUMA_GO;
			slpm_pkg::ST_LUMA_GO: state_nx = slpm_pkg::ST_LUMA_WAIT;
			slpm_pkg::ST_LUMA_WAIT:
				if (luma.done) state_nx = slpm_pkg::ST_OUT;
			slpm_pkg::ST_OUT:
				if (out_free)
					state_nx = (!sel_q && em1_q) ? slpm_pkg::ST_LUMA_GO : slpm_pkg::ST_IDLE;
			default: state_nx = slpm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= slpm_pkg::ST_CLEAR;
		else
			state_q <= state_nx;
	end

	// memory control by state
	always_comb begin
		s_axis_tready = (state_q == slpm_pkg::ST_IDLE);
		row_we    = 1'b0;
		row_waddr = col_q;
		old_wdata = '0;
		new_wdata = '0;
		new_re    = 1'b0;
		old_re    = 1'b0;
		new_raddr = col_q;
		old_raddr = col_q;
		pal_we    = accept && (s_axis_tuser == slpm_pkg::CMD_PAL);
		pal_re    = (state_q == slpm_pkg::ST_LUMA_WAIT) && luma.done;
		pal_wdata = {s_axis_tdata[23:8], s_axis_tdata[7:0] + slpm_pkg::BLUE_OFS};
		unique case (state_q)
			slpm_pkg::ST_CLEAR: begin
				row_we    = 1'b1;
				row_waddr = clr_q;
			end
			slpm_pkg::ST_P_RD0: begin
				new_re    = 1'b1;
				old_re    = 1'b1;
				old_raddr = col_q - AW'(1);
			end
			slpm_pkg::ST_P_RD1: old_re = 1'b1;
			slpm_pkg::ST_P_WR0: begin
				row_we    = (col_q != '0);
				row_waddr = col_q - AW'(1);
				old_wdata = win1_q;
				new_wdata = win2_q;
			end
			slpm_pkg::ST_P_WR1: begin
				row_we    = lastcol;
				old_wdata = rgt_q;
				new_wdata = pix_q;
			end
			slpm_pkg::ST_F_RD0: begin
				new_re = 1'b1;
				old_re = 1'b1;
			end
			slpm_pkg::ST_F_RD1: begin
				new_re    = 1'b1;
				new_raddr = (col_q == '0) ? AW'(1) : col_q - AW'(1);
			end
			slpm_pkg::ST_F_RD2: begin
				new_re    = 1'b1;
				new_raddr = lastcol ? col_q - AW'(1) : col_q + AW'(1);
			end
			default: ;
		endcase
	end

	// kernel operands with the mirrored edges
	always_comb begin
		up0   = (row_q == slpm_pkg::ROW_W'(1)) ? win2_q : upa_q;
		left0 = (col_q == AW'(1)) ? rgt_q : win0_q;
		up1   = (row_q == slpm_pkg::ROW_W'(1)) ? pix_q : upb_q;
	end

	// counters and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else begin
			if (state_q == slpm_pkg::ST_CLEAR)
				clr_q <= clr_q + AW'(1);
			if (state_q == slpm_pkg::ST_P_WR1) begin
				if (lastcol) begin
					col_q <= '0;
					row_q <= row_q + slpm_pkg::ROW_W'(1);
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
			if (state_q == slpm_pkg::ST_F_RD3) begin
				if (lastcol) begin
					col_q <= '0;
					row_q <= '0;
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

	// window and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q  <= '0;
			win1_q  <= '0;
			win2_q  <= '0;
			em0_q   <= 1'b0;
			em1_q   <= 1'b0;
			sel_q   <= 1'b0;
			fdone_q <= 1'b0;
		end else begin
			if (state_q == slpm_pkg::ST_P_WR0) begin
				em0_q   <= (col_q != '0) && (row_q != '0);
				em1_q   <= lastcol && (row_q != '0);
				fdone_q <= 1'b0;
			end
			if (state_q == slpm_pkg::ST_P_WR1) begin
				win0_q <= win1_q;
				win1_q <= rgt_q;
				win2_q <= pix_q;
				sel_q  <= !em0_q;
			end
			if (state_q == slpm_pkg::ST_F_RD3) begin
				em0_q   <= 1'b1;
				em1_q   <= 1'b0;
				sel_q   <= 1'b0;
				fdone_q <= lastcol;
			end
			if (out_load && !sel_q && em1_q)
				sel_q <= 1'b1;
		end
	end

	// operand capture and kernel results
	always_ff @(posedge clk) begin
		if (accept)
			pix_q <= s_axis_tdata[23:0];
		unique case (state_q)
			slpm_pkg::ST_P_RD1: begin
				rgt_q <= new_rdata;
				upa_q <= old_rdata;
			end
			slpm_pkg::ST_P_RD2: upb_q <= old_rdata;
			slpm_pkg::ST_P_WR0: begin
				sh0_q <= slpm_pkg::sharpen(win1_q, up0, win2_q, left0, rgt_q);
				sh1_q <= slpm_pkg::sharpen(rgt_q, up1, pix_q, win1_q, win1_q);
			end
			slpm_pkg::ST_F_RD1: begin
				ctr_q <= new_rdata;
				old_q <= old_rdata;
			end
			slpm_pkg::ST_F_RD2: lft_q <= new_rdata;
			slpm_pkg::ST_F_RD3:
				sh0_q <= slpm_pkg::sharpen(ctr_q, old_q, old_q, lft_q, new_rdata);
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tvalid <= 1'b0;
		else if (out_load)
			m_axis_tvalid <= 1'b1;
		else if (m_axis_tready)
			m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= pal_rdata;
			m_axis_tuser <= fdone_q;
			m_axis_tlast <= sel_q || !em1_q;
		end
	end

	// row stores and palette
	slpm_ram #(.DEPTH(slpm_pkg::MAX_WIDTH), .DATA_W(slpm_pkg::PIX_W)) u_older (
		.clk(clk), .we(row_we), .waddr(row_waddr), .wdata(old_wdata),
		.re(old_re), .raddr(old_raddr), .rdata(old_rdata)
	);

	slpm_ram #(.DEPTH(slpm_pkg::MAX_WIDTH), .DATA_W(slpm_pkg::PIX_W)) u_newer (
		.clk(clk), .we(row_we), .waddr(row_waddr), .wdata(new_wdata),
		.re(new_re), .raddr(new_raddr), .rdata(new_rdata)
	);

	slpm_ram #(.DEPTH(slpm_pkg::PALETTE_DEPTH), .DATA_W(slpm_pkg::PIX_W)) u_palette (
		.clk(clk), .we(pal_we), .waddr(s_axis_tdata[31:24]), .wdata(pal_wdata),
		.re(pal_re), .raddr(luma.lum), .rdata(pal_rdata)
	);

	// brightness unit
	slpm_luma u_luma (
		.clk(clk), .arst_n(arst_n),
		.start(state_q == slpm_pkg::ST_LUMA_GO),
		.pix(sel_q ? sh1_q : sh0_q),
		.res(luma)
	);

	// palette writes only land while no item is in flight
	a_pal_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pal_we |-> state_q == slpm_pkg::ST_IDLE)
		else $error("palette write outside idle");
	// brightness results arrive only when awaited
	a_luma_wait: assert property (@(posedge clk) disable iff (!arst_n)
		luma.done |-> state_q == slpm_pkg::ST_LUMA_WAIT)
		else $error("unexpected brightness result");
	// a pending result is never overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output overwritten");
	// the second result of an item always ends its run
	a_second_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && sel_q |=> m_axis_tlast)
		else $error("second result without tlast");

endmodule

// ----- tb/sharpen_luma_palette_map_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharpen_luma_palette_map_top_test: self-checking bench for the sharpen block
// Loads the whole palette, then streams directed and random frames of several
// geometries with noise commands. A local model of the row stores, sharpen,
// brightness and palette predicts every output transaction. Both stream sides
// idle at random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module sharpen_luma_palette_map_top_test;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int IDLE_LIMIT = 8000;
	localparam int SETTLE = 80;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] idx;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} map_item_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       done;
		logic       last;
	} map_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;  // pixel_blue, pixel_green, pixel_red, palette_index
	logic [1:0]  s_axis_tuser;  // cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;  // out_blue, out_green, out_red
	logic        m_axis_tuser;  // frame_done
	logic        m_axis_tlast;
	logic        cfg_we;
	logic        cfg_addr;
	logic [11:0] cfg_wdata;

	sharpen_luma_palette_map_top dut (.*);

	// local copy of the block state
	slpm_pkg::pix_t older_row [slpm_pkg::MAX_WIDTH];
	slpm_pkg::pix_t newer_row [slpm_pkg::MAX_WIDTH];
	slpm_pkg::pix_t palette [slpm_pkg::PALETTE_DEPTH];
	slpm_pkg::pix_t window [3];
	int unsigned    row_cnt;
	int unsigned    col_cnt;
	logic [11:0]    width_reg;
	logic [11:0]    height_reg;

	map_item_t   pending_items [$];
	map_result_t expected_colors [$];
	int          error_count = 0;
	int          idle_cycles = 0;

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int draw_gap();
		return $urandom_range(0, 1) ? 0 : $urandom_range(0, 18);
	endfunction

	function automatic slpm_pkg::pix_t sharpen_px(slpm_pkg::pix_t c, slpm_pkg::pix_t u,
	                                              slpm_pkg::pix_t d, slpm_pkg::pix_t l,
	                                              slpm_pkg::pix_t r);
		slpm_pkg::pix_t res;
		int             v;
		for (int k = 0; k < 3; k++) begin
			v = 5 * int'(c[8*k +: 8]) - int'(u[8*k +: 8]) - int'(d[8*k +: 8])
			    - int'(l[8*k +: 8]) - int'(r[8*k +: 8]);
			if (v < 0) v = 0;
			if (v > 255) v = 255;
			res[8*k +: 8] = v[7:0];
		end
		return res;
	endfunction

	// brightness through integer square root, then palette lookup
	function automatic map_result_t color_of(slpm_pkg::pix_t px, logic done);
		int unsigned    sum, root, bitv, lum;
		slpm_pkg::pix_t col;
		map_result_t    res;
		sum = 306 * px[23:16] * px[23:16] + 601 * px[15:8] * px[15:8]
		      + 147 * px[7:0] * px[7:0];
		root = 0;
		bitv = 1 << 30;
		while (bitv > sum) bitv >>= 2;
		while (bitv != 0) begin
			if (sum >= root + bitv) begin
				sum -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		lum = root >> 5;
		if (lum > 255) lum = 255;
		col = palette[lum];
		res.blue = col[7:0];
		res.green = col[15:8];
		res.red = col[23:16];
		res.done = done;
		res.last = 1'b0;
		return res;
	endfunction

	// advance the local state by one accepted transaction
	task automatic predict_colors(map_item_t it);
		int unsigned    w, h, c;
		slpm_pkg::pix_t p, rgt, up, left, right;
		map_result_t    outs [$];
		logic           lastcol, done;
		w = width_reg;
		h = height_reg;
		if (w < 2) w = 2;
		if (w > slpm_pkg::MAX_WIDTH) w = slpm_pkg::MAX_WIDTH;
		if (h < 2) h = 2;
		if (h > slpm_pkg::MAX_HEIGHT) h = slpm_pkg::MAX_HEIGHT;
		p = {it.red, it.green, it.blue};
		case (it.cmd)
			slpm_pkg::CMD_PAL: begin
				palette[it.idx] = {it.red, it.green, it.blue + slpm_pkg::BLUE_OFS};
			end
			slpm_pkg::CMD_PIXEL: begin
				if (row_cnt < h) begin
					c = col_cnt;
					lastcol = (c >= w - 1);
					rgt = newer_row[c];
					if (c >= 1) begin
						if (row_cnt >= 1) begin
							left = (c == 1) ? rgt : window[0];
							up = (row_cnt == 1) ? window[2] : older_row[c-1];
							outs = {outs, color_of(
								sharpen_px(window[1], up, window[2], left, rgt), 1'b0)};
						end
						older_row[c-1] = window[1];
						newer_row[c-1] = window[2];
					end
					if (lastcol) begin
						if (row_cnt >= 1) begin
							up = (row_cnt == 1) ? p : older_row[c];
							outs = {outs, color_of(
								sharpen_px(rgt, up, p, window[1], window[1]), 1'b0)};
						end
						older_row[c] = rgt;
						newer_row[c] = p;
					end
					window[0] = window[1];
					window[1] = rgt;
					window[2] = p;
					if (lastcol) begin
						col_cnt = 0;
						row_cnt++;
					end else begin
						col_cnt = c + 1;
					end
				end
			end
			slpm_pkg::CMD_FLUSH: begin
				if (row_cnt >= h) begin
					c = col_cnt;
					done = (c >= w - 1);
					left = (c == 0) ? newer_row[1] : newer_row[c-1];
					right = done ? newer_row[c-1] : newer_row[c+1];
					outs = {outs, color_of(sharpen_px(newer_row[c], older_row[c],
						older_row[c], left, right), done)};
					if (done) begin
						row_cnt = 0;
						col_cnt = 0;
					end else begin
						col_cnt = c + 1;
					end
				end
			end
			default: ;
		endcase
		if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
		expected_colors = {expected_colors, outs};
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	// input driver
	int        in_gap;
	map_item_t cur_item;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			in_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) predict_colors(cur_item);
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the offered transaction
			end else if (in_gap > 0) begin
				in_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				cur_item = pending_items.pop_front();
				s_axis_tdata <= {cur_item.idx, cur_item.red, cur_item.green, cur_item.blue};
				s_axis_tuser <= cur_item.cmd;
				s_axis_tvalid <= 1'b1;
				in_gap = draw_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output monitor and receiver stalls
	int          out_stall;
	int          hold_left;
	int          results_seen;
	map_result_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			out_stall = 0;
			hold_left = 0;
			results_seen = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (results_seen == 300) hold_left = 1500;
				out_stall = draw_gap();
				if (expected_colors.size() == 0) begin
					report_mismatch("unexpected transaction", 1, 0);
				end else begin
					want = expected_colors.pop_front();
					if (m_axis_tdata[7:0] !== want.blue)
						report_mismatch("blue", m_axis_tdata[7:0], want.blue);
					if (m_axis_tdata[15:8] !== want.green)
						report_mismatch("green", m_axis_tdata[15:8], want.green);
					if (m_axis_tdata[23:16] !== want.red)
						report_mismatch("red", m_axis_tdata[23:16], want.red);
					if (m_axis_tuser !== want.done)
						report_mismatch("frame_done", m_axis_tuser, want.done);
					if (m_axis_tlast !== want.last)
						report_mismatch("last", m_axis_tlast, want.last);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (out_stall > 0) begin
				out_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("FAIL sharpen_luma_palette_map_top");
			$finish;
		end
	end

	function automatic logic [7:0] chan_value();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic map_item_t make_item(logic [1:0] cmd);
		map_item_t it;
		it.cmd = cmd;
		it.blue = chan_value();
		it.green = chan_value();
		it.red = chan_value();
		it.idx = 8'($urandom_range(0, 255));
		return it;
	endfunction

	// sampled away from the active edge so driver updates are settled
	task automatic wait_drained();
		@(negedge clk);
		while (pending_items.size() > 0 || s_axis_tvalid || expected_colors.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic addr, logic [11:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (addr == slpm_pkg::REG_FRAME_WIDTH) width_reg = value;
		else height_reg = value;
	endtask

	// one frame of rows x cols pixels followed by its drain, with optional noise
	task automatic queue_frame(int cols, int rows, bit noisy, inout int count);
		for (int r = 0; r < rows; r++)
			for (int c = 0; c < cols; c++) begin
				if (noisy && $urandom_range(0, 19) == 0)
					pending_items = {pending_items, make_item(2'($urandom_range(0, 3)))};
				pending_items = {pending_items, make_item(slpm_pkg::CMD_PIXEL)};
				count++;
			end
		for (int c = 0; c < cols; c++) begin
			if (noisy && $urandom_range(0, 14) == 0)
				pending_items = {pending_items,
					make_item($urandom_range(0, 1) ? slpm_pkg::CMD_PIXEL : CMD_NONE)};
			pending_items = {pending_items, make_item(slpm_pkg::CMD_FLUSH)};
			count++;
		end
	endtask

	int item_count;
	int w, h;
	initial begin
		map_item_t it;
		cfg_we = 1'b0;
		cfg_addr = 1'b0;
		cfg_wdata = '0;
		item_count = 0;
		width_reg = slpm_pkg::WIDTH_RST;
		height_reg = slpm_pkg::HEIGHT_RST;
		row_cnt = 0;
		col_cnt = 0;
		foreach (older_row[i]) older_row[i] = '0;
		foreach (newer_row[i]) newer_row[i] = '0;
		foreach (palette[i]) palette[i] = '0;
		foreach (window[i]) window[i] = '0;
		@(posedge arst_n);

		// full palette load, every index once
		for (int i = 0; i < slpm_pkg::PALETTE_DEPTH; i++) begin
			it = make_item(slpm_pkg::CMD_PAL);
			it.idx = 8'(i);
			pending_items = {pending_items, it};
		end

		// smallest frame with register values below the clamp
		write_reg(slpm_pkg::REG_FRAME_WIDTH, 12'd0);
		write_reg(slpm_pkg::REG_FRAME_HEIGHT, 12'd1);
		it = make_item(slpm_pkg::CMD_FLUSH);   // flush before the last row is in
		pending_items = {pending_items, it};
		it = make_item(CMD_NONE);              // unused command
		pending_items = {pending_items, it};
		it = '{slpm_pkg::CMD_PIXEL, 8'h00, 8'hff, 8'hff, 8'hff};
		pending_items = {pending_items, it};
		it = '{slpm_pkg::CMD_PIXEL, 8'hff, 8'h00, 8'h00, 8'h00};
		pending_items = {pending_items, it};
		it = '{slpm_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00};
		pending_items = {pending_items, it};
		it = '{slpm_pkg::CMD_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff};
		pending_items = {pending_items, it};
		pending_items = {pending_items, make_item(slpm_pkg::CMD_FLUSH)};
		pending_items = {pending_items, make_item(slpm_pkg::CMD_PIXEL)};   // pixel during drain
		pending_items = {pending_items, make_item(slpm_pkg::CMD_FLUSH)};

		// width 3 by height 2, then width 2 by height 3
		write_reg(slpm_pkg::REG_FRAME_WIDTH, 12'd3);
		write_reg(slpm_pkg::REG_FRAME_HEIGHT, 12'd2);
		queue_frame(3, 2, 1'b0, item_count);
		write_reg(slpm_pkg::REG_FRAME_WIDTH, 12'd2);
		write_reg(slpm_pkg::REG_FRAME_HEIGHT, 12'd3);
		queue_frame(2, 3, 1'b0, item_count);

		// tallest setting, cut short by lowering the height while idle
		write_reg(slpm_pkg::REG_FRAME_HEIGHT, 12'd4095);
		for (int i = 0; i < 6; i++)
			pending_items = {pending_items, make_item(slpm_pkg::CMD_PIXEL)};
		write_reg(slpm_pkg::REG_FRAME_HEIGHT, 12'd2);
		pending_items = {pending_items, make_item(slpm_pkg::CMD_FLUSH)};
		pending_items = {pending_items, make_item(slpm_pkg::CMD_FLUSH)};

		// random frames of small size
		item_count = 0;
		w = 5;
		h = 4;
		write_reg(slpm_pkg::REG_FRAME_WIDTH, 12'(w));
		write_reg(slpm_pkg::REG_FRAME_HEIGHT, 12'(h));
		while (item_count < 700) begin
			if ($urandom_range(0, 2) == 0) begin
				w = $urandom_range(2, 9);
				h = $urandom_range(2, 5);
				write_reg(slpm_pkg::REG_FRAME_WIDTH, 12'(w));
				write_reg(slpm_pkg::REG_FRAME_HEIGHT, 12'(h));
			end
			queue_frame(w, h, 1'b1, item_count);
			wait_drained();
		end

		wait_drained();
		if (error_count == 0)
			$display("PASS sharpen_luma_palette_map_top");
		else
			$display("FAIL sharpen_luma_palette_map_top");
		$finish;
	end

endmodule

// ----- sharpen_luma_palette_map_top.f -----
rtl/slpm_pkg.sv
rtl/slpm_ram.sv
rtl/slpm_luma.sv
rtl/sharpen_luma_palette_map_top.sv
tb/sharpen_luma_palette_map_top_test.sv
